### rtl/core/isingcb_pkg.sv
// Shared types, codes and helpers of the checkerboard Ising lattice block.
package isingcb_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_MEASURE = 2'd2,
    OP_TOTALS  = 2'd3
  } isingcb_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QUOT,
    ST_REM,
    ST_LOAD,
    ST_RD_UP,
    ST_RD_SAME,
    ST_RD_SIDE,
    ST_RD_DOWN,
    ST_EVAL,
    ST_DONE
  } isingcb_state_e;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_TWO  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_FOUR = 1'd1;

  localparam int ENERGY_W = 20;
  localparam int MAGNET_W = 19;
  localparam int DRAW_W   = 16;

  // Magnetization step of a site pair that is all minus.
  localparam logic [MAGNET_W-1:0] MAGNET_MINUS_TWO = -19'sd2;

  typedef struct packed {
    isingcb_op_e        op;
    logic               color;
    logic [7:0]         column;
    logic [7:0]         row;
    logic signed [1:0]  spin_value;
    logic [DRAW_W-1:0]  random_draw;
  } isingcb_item_t;

  typedef struct packed {
    logic signed [MAGNET_W-1:0] magnetization_total;
    logic signed [ENERGY_W-1:0] energy_total;
    logic                       flipped;
    logic signed [1:0]          site_spin;
  } isingcb_result_t;

  typedef struct packed {
    logic [DRAW_W-1:0] accept_four;
    logic [DRAW_W-1:0] accept_two;
  } isingcb_thresh_t;

  // Stored bit 1 means spin -1, 0 means +1.
  function automatic logic signed [1:0] spin_code(input logic neg);
    return neg ? 2'sb11 : 2'sb01;
  endfunction

endpackage

### rtl/core/isingcb_spin_ram.sv
// Single-port one-bit spin memory with registered read data.
module isingcb_spin_ram
  import isingcb_pkg::*;
#(
  parameter int ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic              we_i,
  input  logic              wdata_i,
  output logic              rdata_o
);

  logic mem [2**ADDR_W];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/isingcb_seq.sv
// Site sequencer: coordinate reduction, neighbor reads, Metropolis decision, totals.
module isingcb_seq
  import isingcb_pkg::*;
#(
  parameter int GRID_COLUMNS = 256,
  parameter int GRID_ROWS    = 256
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  isingcb_item_t                          item_i,
  input  isingcb_thresh_t                        thresh_i,
  output logic                                   done_valid_o,
  input  logic                                   done_ready_i,
  output isingcb_result_t                        result_o,
  output logic [$clog2(GRID_ROWS)+$clog2(GRID_COLUMNS)-1:0] red_addr_o,
  output logic                                   red_we_o,
  output logic                                   red_wdata_o,
  input  logic                                   red_rdata_i,
  output logic [$clog2(GRID_ROWS)+$clog2(GRID_COLUMNS)-1:0] black_addr_o,
  output logic                                   black_we_o,
  output logic                                   black_wdata_o,
  input  logic                                   black_rdata_i
);

  localparam int COL_W  = $clog2(GRID_COLUMNS);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int SH     = 24;
  localparam int MUL_W  = 33;
  localparam int REM_W  = 21;
  localparam logic [MUL_W-1:0] COL_MUL = MUL_W'((2**SH + GRID_COLUMNS - 1) / GRID_COLUMNS);
  localparam logic [MUL_W-1:0] ROW_MUL = MUL_W'((2**SH + GRID_ROWS - 1) / GRID_ROWS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);

  isingcb_state_e  state_q, state_d;
  isingcb_item_t   item_q;
  isingcb_result_t result_q;
  logic [7:0]       qcol_q, qrow_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             s_bit_q, same_bit_q;
  logic [2:0]       agree_q;
  logic [ENERGY_W-1:0] energy_sum_q;
  logic [MAGNET_W-1:0] magnet_sum_q;

  logic [MUL_W-1:0] col_prod, row_prod;
  logic [REM_W-1:0] col_rem, row_rem;
  logic [ROW_W-1:0] up_row, down_row;
  logic [COL_W-1:0] side_col;
  logic             shift_left;
  logic             mine_black;
  logic             mine_rdata, other_rdata;
  logic [ADDR_W-1:0] site_addr;
  logic [ADDR_W-1:0] mine_addr, other_addr;
  logic             mine_we, mine_wdata;
  logic [2:0]       agree_fin;
  logic             flip;
  logic [ENERGY_W-1:0] energy_step;
  logic [MAGNET_W-1:0] magnet_step;

  // Floor division by reciprocal multiply; exact for 8-bit coordinates.
  assign col_prod = {25'b0, item_q.column} * COL_MUL;
  assign row_prod = {25'b0, item_q.row} * ROW_MUL;
  assign col_rem  = REM_W'(item_q.column) - REM_W'(qcol_q) * REM_W'(GRID_COLUMNS);
  assign row_rem  = REM_W'(item_q.row) - REM_W'(qrow_q) * REM_W'(GRID_ROWS);

  assign mine_black  = (item_q.op != OP_MEASURE) && item_q.color;
  assign mine_rdata  = mine_black ? black_rdata_i : red_rdata_i;
  assign other_rdata = mine_black ? red_rdata_i : black_rdata_i;

  // Side neighbor goes left for red on even rows, flipped on odd rows and for black.
  assign shift_left = ~(mine_black ^ row_q[0]);
  assign up_row     = (row_q == '0) ? ROW_LAST : row_q - ROW_W'(1);
  assign down_row   = (row_q == ROW_LAST) ? '0 : row_q + ROW_W'(1);
  always_comb begin
    if (shift_left) begin
      side_col = (col_q == '0) ? COL_LAST : col_q - COL_W'(1);
    end else begin
      side_col = (col_q == COL_LAST) ? '0 : col_q + COL_W'(1);
    end
  end

  assign site_addr = {row_q, col_q};

  assign agree_fin = agree_q + {2'b0, other_rdata == s_bit_q};
  always_comb begin
    if (agree_fin <= 3'd2) begin
      flip = 1'b1;
    end else if (agree_fin == 3'd3) begin
      flip = item_q.random_draw <= thresh_i.accept_two;
    end else begin
      flip = item_q.random_draw <= thresh_i.accept_four;
    end
  end

  assign energy_step = {16'b0, agree_fin, 1'b0} - ENERGY_W'(4);
  always_comb begin
    if (s_bit_q != same_bit_q) begin
      magnet_step = '0;
    end else if (s_bit_q) begin
      magnet_step = MAGNET_MINUS_TWO;
    end else begin
      magnet_step = MAGNET_W'(2);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_QUOT;
      ST_QUOT:    state_d = ST_REM;
      ST_REM: begin
        unique case (item_q.op)
          OP_LOAD:   state_d = ST_LOAD;
          OP_TOTALS: state_d = ST_DONE;
          default:   state_d = ST_RD_UP;
        endcase
      end
      ST_LOAD:    state_d = ST_DONE;
      ST_RD_UP:   state_d = ST_RD_SAME;
      ST_RD_SAME: state_d = ST_RD_SIDE;
      ST_RD_SIDE: state_d = ST_RD_DOWN;
      ST_RD_DOWN: state_d = ST_EVAL;
      ST_EVAL:    state_d = ST_DONE;
      ST_DONE:    if (done_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Memory port drive.
  always_comb begin
    mine_addr  = site_addr;
    other_addr = site_addr;
    mine_we    = 1'b0;
    mine_wdata = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        mine_we    = 1'b1;
        mine_wdata = item_q.spin_value[1];
      end
      ST_RD_UP:   other_addr = {up_row, col_q};
      ST_RD_SIDE: other_addr = {row_q, side_col};
      ST_RD_DOWN: other_addr = {down_row, col_q};
      ST_EVAL: begin
        mine_we    = flip && (item_q.op == OP_UPDATE);
        mine_wdata = ~s_bit_q;
      end
      default: ;
    endcase
  end

  assign red_addr_o    = mine_black ? other_addr : mine_addr;
  assign red_we_o      = !mine_black && mine_we;
  assign red_wdata_o   = mine_wdata;
  assign black_addr_o  = mine_black ? mine_addr : other_addr;
  assign black_we_o    = mine_black && mine_we;
  assign black_wdata_o = mine_wdata;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign done_valid_o = (state_q == ST_DONE);
  assign result_o     = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      energy_sum_q <= '0;
      magnet_sum_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_REM && item_q.op == OP_TOTALS) begin
        energy_sum_q <= '0;
        magnet_sum_q <= '0;
      end else if (state_q == ST_EVAL && item_q.op == OP_MEASURE) begin
        energy_sum_q <= energy_sum_q + energy_step;
        magnet_sum_q <= magnet_sum_q + magnet_step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
    unique case (state_q)
      ST_QUOT: begin
        qcol_q <= col_prod[SH+7:SH];
        qrow_q <= row_prod[SH+7:SH];
      end
      ST_REM: begin
        col_q <= col_rem[COL_W-1:0];
        row_q <= row_rem[ROW_W-1:0];
        if (item_q.op == OP_TOTALS) begin
          result_q.site_spin           <= '0;
          result_q.flipped             <= 1'b0;
          result_q.energy_total        <= '0 - energy_sum_q;
          result_q.magnetization_total <= magnet_sum_q;
        end
      end
      ST_LOAD: begin
        result_q.site_spin           <= spin_code(item_q.spin_value[1]);
        result_q.flipped             <= 1'b0;
        result_q.energy_total        <= '0;
        result_q.magnetization_total <= '0;
      end
      ST_RD_SAME: begin
        // own spin and up neighbor land together
        s_bit_q <= mine_rdata;
        agree_q <= {2'b0, other_rdata == mine_rdata};
      end
      ST_RD_SIDE: begin
        same_bit_q <= other_rdata;
        agree_q    <= agree_fin;
      end
      ST_RD_DOWN: agree_q <= agree_fin;
      ST_EVAL: begin
        if (item_q.op == OP_UPDATE) begin
          result_q.site_spin <= spin_code(s_bit_q ^ flip);
          result_q.flipped   <= flip;
        end else begin
          result_q.site_spin <= spin_code(s_bit_q);
          result_q.flipped   <= 1'b0;
        end
        result_q.energy_total        <= '0;
        result_q.magnetization_total <= '0;
      end
      default: ;
    endcase
  end

  a_we_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (red_we_o || black_we_o) |-> (state_q == ST_LOAD || state_q == ST_EVAL))
    else $error("spin write outside load or evaluate");

  a_we_one_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(red_we_o && black_we_o))
    else $error("both half-grids written at once");

  a_totals_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REM && item_q.op == OP_TOTALS)
      |=> (energy_sum_q == '0 && magnet_sum_q == '0))
    else $error("totals not cleared after read");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_QUOT))
    else $error("accepted beat did not start reduction");

  a_forced_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && item_q.op == OP_UPDATE && agree_fin <= 3'd2)
      |=> result_q.flipped)
    else $error("non-positive energy change did not flip");

endmodule

### rtl/core/ising_checkerboard_metropolis_top.sv
// Top level of the checkerboard Metropolis Ising lattice block.
// Usage:
//   Input beats on s_axis carry one operation each: load a spin, update a site,
//   measure a red site, or read and clear the energy and magnetization totals.
//   Every beat yields exactly one result beat on m_axis, in order.
//   The cfg channel writes the two acceptance thresholds (index 0: energy
//   change 2, index 1: energy change 4); write it only while the block is idle.
// Sequence:
//   One item is in work at a time. Coordinate reduction runs in the quotient
//   and remainder states, then a load writes its spin, a totals read goes to
//   the result, and an update or measure reads its neighbors and evaluates:
//   the four neighbor reads go one per cycle through the single port of the
//   other half-grid memory, whose read data is registered. The next beat is
//   accepted only once the result has been handed to the output register.
// Reset and stall:
//   Reset clears the thresholds and the totals; spin memories are not cleared
//   and a site must be loaded before it is read. A result waits in the output
//   register while m_axis_tready is low; the next item is still accepted and
//   processed, and holds at its end until the output register frees up.
module ising_checkerboard_metropolis_top
  import isingcb_pkg::*;
#(
  parameter int GRID_COLUMNS = 256,
  parameter int GRID_ROWS    = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // column[7:0], row[15:8], spin_value[17:16], random_draw[33:18], zero pad
  input  logic [39:0]          s_axis_tdata,
  // op[1:0], color[2]
  input  logic [2:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // site_spin[1:0], flipped[2], energy_total[22:3], magnetization_total[41:23], zero pad
  output logic [47:0]          m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DRAW_W-1:0]    cfg_data_i
);

  localparam int ADDR_W = $clog2(GRID_ROWS) + $clog2(GRID_COLUMNS);

  isingcb_thresh_t thresh_q;
  isingcb_item_t   item;
  isingcb_result_t result;
  isingcb_result_t out_q;
  logic            out_valid_q;
  logic            done_valid, done_ready;
  logic [ADDR_W-1:0] red_addr, black_addr;
  logic            red_we, black_we, red_wdata, black_wdata;
  logic            red_rdata, black_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ACCEPT_TWO:  thresh_q.accept_two  <= cfg_data_i;
        REG_ACCEPT_FOUR: thresh_q.accept_four <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign item.op          = isingcb_op_e'(s_axis_tuser[1:0]);
  assign item.color       = s_axis_tuser[2];
  assign item.column      = s_axis_tdata[7:0];
  assign item.row         = s_axis_tdata[15:8];
  assign item.spin_value  = s_axis_tdata[17:16];
  assign item.random_draw = s_axis_tdata[33:18];

  isingcb_seq #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .item_i        (item),
    .thresh_i      (thresh_q),
    .done_valid_o  (done_valid),
    .done_ready_i  (done_ready),
    .result_o      (result),
    .red_addr_o    (red_addr),
    .red_we_o      (red_we),
    .red_wdata_o   (red_wdata),
    .red_rdata_i   (red_rdata),
    .black_addr_o  (black_addr),
    .black_we_o    (black_we),
    .black_wdata_o (black_wdata),
    .black_rdata_i (black_rdata)
  );

  isingcb_spin_ram #(.ADDR_W(ADDR_W)) u_red_ram (
    .clk_i   (clk_i),
    .addr_i  (red_addr),
    .we_i    (red_we),
    .wdata_i (red_wdata),
    .rdata_o (red_rdata)
  );

  isingcb_spin_ram #(.ADDR_W(ADDR_W)) u_black_ram (
    .clk_i   (clk_i),
    .addr_i  (black_addr),
    .we_i    (black_we),
    .wdata_i (black_wdata),
    .rdata_o (black_rdata)
  );

  // Output register: take a finished result when empty or being drained.
  assign done_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_ready) begin
      out_valid_q <= done_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_ready && done_valid) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q};

endmodule
